@@ rtl/blpc_pkg.sv @@
// Package for the LED blink pattern controller: item codes, pattern codes,
// register indexes, reset values and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blpc_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned PERIOD_W = 8;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned SEL_W    = 2;
    localparam int unsigned PAT_W    = 3;
    localparam int unsigned OUT_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Item kinds carried by the mode field.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    // Pattern codes of a command.
    typedef enum logic [PAT_W-1:0] {
        PAT_OFF    = 3'd0,
        PAT_ON     = 3'd1,
        PAT_SLOW   = 3'd2,
        PAT_MEDIUM = 3'd3,
        PAT_FAST   = 3'd4,
        PAT_BURST1 = 3'd5,
        PAT_BURST3 = 3'd6,
        PAT_BURST5 = 3'd7
    } pattern_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW   = 2'd0,
        REG_MEDIUM = 2'd1,
        REG_FAST   = 2'd2,
        REG_BURST  = 2'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [PERIOD_W-1:0] SLOW_RESET   = 8'd100;
    localparam logic [PERIOD_W-1:0] MEDIUM_RESET = 8'd40;
    localparam logic [PERIOD_W-1:0] FAST_RESET   = 8'd4;
    localparam logic [PERIOD_W-1:0] BURST_RESET  = 8'd7;

    // Blink counts of the burst patterns.
    localparam logic [COUNT_W-1:0] BURST1_COUNT = 8'd1;
    localparam logic [COUNT_W-1:0] BURST3_COUNT = 8'd3;
    localparam logic [COUNT_W-1:0] BURST5_COUNT = 8'd5;

    // Current period settings seen by every LED.
    typedef struct packed {
        logic [PERIOD_W-1:0] slow;
        logic [PERIOD_W-1:0] mid;
        logic [PERIOD_W-1:0] fast;
        logic [PERIOD_W-1:0] burst;
    } periods_t;

    // Event presented to one LED in the cycle a request is accepted.
    typedef struct packed {
        logic     tick;
        logic     cmd_hit;
        pattern_t pattern;
    } led_event_t;

    // Status of one LED after the event.
    typedef struct packed {
        logic level;
        logic active;
    } led_status_t;

endpackage

`default_nettype wire

@@ rtl/blpc_led_cell.sv @@
// Blink state machine of one LED: period, tick counter, burst count and level.
// Depends on blpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blpc_led_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  blpc_pkg::periods_t        periods,
    input  blpc_pkg::led_event_t      evt,
    output blpc_pkg::led_status_t     status_next
);

    logic [blpc_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [blpc_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [blpc_pkg::COUNT_W-1:0]  blinks_reg, blinks_next;
    logic                          burst_reg, burst_next;
    logic                          level_reg, level_next;
    logic [blpc_pkg::COUNT_W-1:0]  cnt_inc;

    assign cnt_inc = cnt_reg + blpc_pkg::COUNT_W'(1);

    // Next state for a command or a tick.
    always_comb begin
        period_next = period_reg;
        cnt_next    = cnt_reg;
        blinks_next = blinks_reg;
        burst_next  = burst_reg;
        level_next  = level_reg;
        if (evt.cmd_hit) begin
            cnt_next   = '0;
            burst_next = 1'b0;
            case (evt.pattern)
                blpc_pkg::PAT_OFF: begin
                    period_next = '0;
                    level_next  = 1'b0;
                end
                blpc_pkg::PAT_ON: begin
                    period_next = '0;
                    level_next  = 1'b1;
                end
                blpc_pkg::PAT_SLOW:   period_next = periods.slow;
                blpc_pkg::PAT_MEDIUM: period_next = periods.mid;
                blpc_pkg::PAT_FAST:   period_next = periods.fast;
                blpc_pkg::PAT_BURST1: begin
                    burst_next  = 1'b1;
                    period_next = periods.burst;
                    blinks_next = blpc_pkg::BURST1_COUNT;
                end
                blpc_pkg::PAT_BURST3: begin
                    burst_next  = 1'b1;
                    period_next = periods.burst;
                    blinks_next = blpc_pkg::BURST3_COUNT;
                end
                blpc_pkg::PAT_BURST5: begin
                    burst_next  = 1'b1;
                    period_next = periods.burst;
                    blinks_next = blpc_pkg::BURST5_COUNT;
                end
                default: begin
                    period_next = period_reg;
                end
            endcase
        end else if (evt.tick && (period_reg != '0)) begin
            cnt_next = cnt_inc;
            // Past half the period the LED goes low.
            if (cnt_inc > (period_reg >> 1)) begin
                level_next = 1'b0;
                if (burst_reg && (blinks_reg == '0)) begin
                    // Burst finished: stop blinking.
                    period_next = '0;
                    burst_next  = 1'b0;
                end else if (cnt_inc == period_reg) begin
                    // End of a period: restart high and count one blink.
                    cnt_next    = '0;
                    level_next  = 1'b1;
                    blinks_next = blinks_reg - blpc_pkg::COUNT_W'(1);
                end
            end
        end
    end

    // State registers; every LED starts off and inactive.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            cnt_reg    <= '0;
            blinks_reg <= '0;
            burst_reg  <= 1'b0;
            level_reg  <= 1'b0;
        end else begin
            period_reg <= period_next;
            cnt_reg    <= cnt_next;
            blinks_reg <= blinks_next;
            burst_reg  <= burst_next;
            level_reg  <= level_next;
        end
    end

    assign status_next.level  = level_next;
    assign status_next.active = (period_next != '0);

endmodule

`default_nettype wire

@@ rtl/led_blink_pattern_controller_unit.sv @@
// Top level of the LED blink pattern controller: period registers, one blink
// cell per LED and the result register. Depends on blpc_pkg, blpc_led_cell.
//
//  Channel   Ports                                      Direction
//  input     s_valid s_ready s_mode s_led_select s_pattern  in (request)
//  result    m_valid m_ready m_led_levels m_active_mask     out (request)
//  config    cfg_wr_en cfg_index cfg_wdata                 in (write only)
//
// For every request the LED cells update their state and the result register
// captures the new levels at the edge that accepts it.
// One request per cycle is sustained; s_ready drops only while a result
// waits in the result register and m_ready is low.
// Reset clears all LEDs to off and inactive and loads the period defaults.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pattern_controller_unit #(
    parameter int unsigned NUM_LEDS = 3
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [blpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [blpc_pkg::PERIOD_W-1:0]     cfg_wdata,
    // Input requests
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic [blpc_pkg::SEL_W-1:0]        s_led_select,
    input  wire logic [blpc_pkg::PAT_W-1:0]        s_pattern,
    // Results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [blpc_pkg::OUT_W-1:0]             m_led_levels,
    output logic [blpc_pkg::OUT_W-1:0]             m_active_mask
);

    blpc_pkg::periods_t            periods_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [blpc_pkg::OUT_W-1:0]    levels_reg, levels_next;
    logic [blpc_pkg::OUT_W-1:0]    active_reg, active_next;
    logic                          accept;
    blpc_pkg::led_status_t         status [NUM_LEDS];

    // A request is taken whenever the result register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Period registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            periods_reg.slow  <= blpc_pkg::SLOW_RESET;
            periods_reg.mid   <= blpc_pkg::MEDIUM_RESET;
            periods_reg.fast  <= blpc_pkg::FAST_RESET;
            periods_reg.burst <= blpc_pkg::BURST_RESET;
        end else if (cfg_wr_en) begin
            case (blpc_pkg::cfg_index_t'(cfg_index))
                blpc_pkg::REG_SLOW:   periods_reg.slow  <= cfg_wdata;
                blpc_pkg::REG_MEDIUM: periods_reg.mid   <= cfg_wdata;
                blpc_pkg::REG_FAST:   periods_reg.fast  <= cfg_wdata;
                blpc_pkg::REG_BURST:  periods_reg.burst <= cfg_wdata;
                default: begin
                    periods_reg <= periods_reg;
                end
            endcase
        end
    end

    // One blink cell per LED; a command reaches only the LED it selects.
    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
        blpc_pkg::led_event_t evt;

        assign evt.tick    = accept && (s_mode == blpc_pkg::MODE_TICK);
        assign evt.cmd_hit = accept && (s_mode == blpc_pkg::MODE_CMD)
                             && (32'(s_led_select) == g);
        assign evt.pattern = blpc_pkg::pattern_t'(s_pattern);

        blpc_led_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .periods     (periods_reg),
            .evt         (evt),
            .status_next (status[g])
        );
    end

    // Gather the reported LEDs into the result fields.
    for (genvar b = 0; b < blpc_pkg::OUT_W; b++) begin : g_out
        if (b < NUM_LEDS) begin : g_used
            assign levels_next[b] = status[b].level;
            assign active_next[b] = status[b].active;
        end else begin : g_unused
            assign levels_next[b] = 1'b0;
            assign active_next[b] = 1'b0;
        end
    end

    // Result valid follows acceptance and delivery.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is loaded with the state left by the accepted request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            levels_reg <= levels_next;
            active_reg <= active_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_led_levels  = levels_reg;
    assign m_active_mask = active_reg;

endmodule

`default_nettype wire

@@ rtl/blpc_checker.sv @@
// Port-level checks for the LED blink pattern controller, bound to the top.
// Depends on blpc_pkg and led_blink_pattern_controller_unit.
`timescale 1ns / 1ps
`default_nettype none

module blpc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            s_mode,
    input wire logic [blpc_pkg::SEL_W-1:0]      s_led_select,
    input wire logic [blpc_pkg::PAT_W-1:0]      s_pattern,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [blpc_pkg::OUT_W-1:0]      m_led_levels,
    input wire logic [blpc_pkg::OUT_W-1:0]      m_active_mask
);

    // The result register comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every accepted request produces a result in the next cycle.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted request gave no result");

    // An empty or draining result register never blocks the input.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with room for a result");

    // A pending result holds until it is taken.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before delivery");

    // An off command to the first LED leaves it low and inactive.
    a_off_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == blpc_pkg::MODE_CMD)
         && (s_led_select == '0) && (s_pattern == blpc_pkg::PAT_OFF))
        |=> (!m_led_levels[0] && !m_active_mask[0]))
        else $error("off command did not switch the LED off");

endmodule

bind led_blink_pattern_controller_unit blpc_checker u_blpc_checker (.*);

`default_nettype wire

@@ sim/tb_led_blink_pattern_controller_unit.sv @@
// Self-checking testbench for led_blink_pattern_controller_unit: drives tick and
// pattern requests, predicts LED levels and active mask per request, checks each result.
// Depends on blpc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_led_blink_pattern_controller_unit;

    localparam int unsigned NUM_LEDS    = 3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;

    // LED select codes; the fourth select value addresses no LED.
    localparam logic [blpc_pkg::SEL_W-1:0] SEL_GREEN = 2'd0;
    localparam logic [blpc_pkg::SEL_W-1:0] SEL_RED   = 2'd1;
    localparam logic [blpc_pkg::SEL_W-1:0] SEL_BLUE  = 2'd2;
    localparam logic [blpc_pkg::SEL_W-1:0] SEL_NONE  = 2'd3;

    typedef struct packed {
        logic [blpc_pkg::OUT_W-1:0] levels;
        logic [blpc_pkg::OUT_W-1:0] active;
    } led_report_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [blpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [blpc_pkg::PERIOD_W-1:0]  cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_mode;
    logic [blpc_pkg::SEL_W-1:0]     s_led_select;
    logic [blpc_pkg::PAT_W-1:0]     s_pattern;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [blpc_pkg::OUT_W-1:0]     m_led_levels;
    logic [blpc_pkg::OUT_W-1:0]     m_active_mask;

    // Predicted blink state, one entry per LED, plus the period registers.
    logic [blpc_pkg::PERIOD_W-1:0] led_period      [NUM_LEDS];
    logic [blpc_pkg::COUNT_W-1:0]  led_count       [NUM_LEDS];
    logic [blpc_pkg::COUNT_W-1:0]  led_blinks_left [NUM_LEDS];
    logic                          led_burst       [NUM_LEDS];
    logic                          led_on          [NUM_LEDS];
    logic [blpc_pkg::PERIOD_W-1:0] slow_ticks;
    logic [blpc_pkg::PERIOD_W-1:0] medium_ticks;
    logic [blpc_pkg::PERIOD_W-1:0] fast_ticks;
    logic [blpc_pkg::PERIOD_W-1:0] burst_ticks;

    led_report_t pending_led_reports[$];
    led_report_t oldest_report;

    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    logic        hold_start        = 1'b0;
    int unsigned hold_left         = 0;
    int unsigned cycle_count       = 0;
    int          mismatch_count    = 0;
    int          tick_requests     = 0;
    int          command_requests  = 0;
    int          results_checked   = 0;
    int          bursts_finished   = 0;
    int          period_settings   = 0;

    led_blink_pattern_controller_unit #(
        .NUM_LEDS(NUM_LEDS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_led_select (s_led_select),
        .s_pattern    (s_pattern),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_levels (m_led_levels),
        .m_active_mask(m_active_mask)
    );

    always #4 aclk = ~aclk;

    // Run limit, counted in clock cycles.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_led_reports.size());
            $display("[led_blink_pattern_controller_unit] ERROR");
            $finish;
        end
    end

    // Long receiver hold-off, started by a one-cycle pulse.
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side: random back-pressure, and each accepted result is checked
    // against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_led_reports.size() == 0) begin
                report_mismatch("result with no request pending, levels", m_led_levels, 'x);
            end else begin
                oldest_report = pending_led_reports.pop_front();
                results_checked++;
                if (m_led_levels !== oldest_report.levels)
                    report_mismatch("led_levels", m_led_levels, oldest_report.levels);
                if (m_active_mask !== oldest_report.active)
                    report_mismatch("active_mask", m_active_mask, oldest_report.active);
            end
        end
        m_ready <= !hold_start && (hold_left == 0) &&
                   ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    task automatic report_mismatch(input string what,
                                   input logic [blpc_pkg::OUT_W-1:0] got,
                                   input logic [blpc_pkg::OUT_W-1:0] want);
        if (mismatch_count < 40)
            $display("mismatch in %s: got %b, predicted %b (cycle %0d)",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // One tick for one LED: counter advance, half-period low, period-end high.
    function automatic void tick_one_led(input int led);
        logic [blpc_pkg::PERIOD_W-1:0] p;
        p = led_period[led];
        if (p == 0) return;
        led_count[led] = led_count[led] + 1'b1;
        if (led_count[led] <= (p >> 1)) return;
        led_on[led] = 1'b0;
        if (led_burst[led] && led_blinks_left[led] == 0) begin
            // Burst has run out: the LED stays low and goes inactive.
            led_period[led] = '0;
            led_burst[led]  = 1'b0;
            bursts_finished++;
            return;
        end
        if (led_count[led] == p) begin
            led_count[led]       = '0;
            led_on[led]          = 1'b1;
            led_blinks_left[led] = led_blinks_left[led] - 1'b1;
        end
    endfunction

    // A pattern command; it always restarts the LED's counter.
    function automatic void apply_pattern(input int led, input blpc_pkg::pattern_t pat);
        led_count[led] = '0;
        led_burst[led] = 1'b0;
        case (pat)
            blpc_pkg::PAT_OFF: begin
                led_period[led] = '0;
                led_on[led]     = 1'b0;
            end
            blpc_pkg::PAT_ON: begin
                led_period[led] = '0;
                led_on[led]     = 1'b1;
            end
            blpc_pkg::PAT_SLOW:   led_period[led] = slow_ticks;
            blpc_pkg::PAT_MEDIUM: led_period[led] = medium_ticks;
            blpc_pkg::PAT_FAST:   led_period[led] = fast_ticks;
            default: begin
                led_burst[led]  = 1'b1;
                led_period[led] = burst_ticks;
                case (pat)
                    blpc_pkg::PAT_BURST1: led_blinks_left[led] = blpc_pkg::BURST1_COUNT;
                    blpc_pkg::PAT_BURST3: led_blinks_left[led] = blpc_pkg::BURST3_COUNT;
                    default:              led_blinks_left[led] = blpc_pkg::BURST5_COUNT;
                endcase
            end
        endcase
    endfunction

    // Predicted result of one accepted request.
    function automatic led_report_t predict_led_report(
            input logic mode,
            input logic [blpc_pkg::SEL_W-1:0] sel,
            input logic [blpc_pkg::PAT_W-1:0] pat);
        led_report_t r;
        if (mode == blpc_pkg::MODE_CMD) begin
            if (sel < NUM_LEDS) apply_pattern(int'(sel), blpc_pkg::pattern_t'(pat));
        end else begin
            for (int i = 0; i < NUM_LEDS; i++) tick_one_led(i);
        end
        r = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            r.levels[i] = led_on[i];
            r.active[i] = (led_period[i] != 0);
        end
        return r;
    endfunction

    // Send one request; valid stays up after acceptance so the next request can follow
    // back to back.
    task automatic send_request(input logic mode,
                                input logic [blpc_pkg::SEL_W-1:0] sel,
                                input logic [blpc_pkg::PAT_W-1:0] pat);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_led_select <= sel;
        s_pattern    <= pat;
        do @(posedge aclk); while (!s_ready);
        pending_led_reports.push_back(predict_led_report(mode, sel, pat));
        if (mode == blpc_pkg::MODE_CMD) command_requests++;
        else tick_requests++;
    endtask

    task automatic send_tick();
        send_request(blpc_pkg::MODE_TICK, blpc_pkg::SEL_W'($urandom_range(0, 3)),
                     blpc_pkg::PAT_W'($urandom_range(0, 7)));
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (pending_led_reports.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all four period registers in back-to-back cycles; only while idle.
    task automatic write_periods(input logic [blpc_pkg::PERIOD_W-1:0] slow,
                                 input logic [blpc_pkg::PERIOD_W-1:0] mid,
                                 input logic [blpc_pkg::PERIOD_W-1:0] fast,
                                 input logic [blpc_pkg::PERIOD_W-1:0] burst);
        cfg_wr_en <= 1'b1;
        cfg_index <= blpc_pkg::REG_SLOW;
        cfg_wdata <= slow;
        @(posedge aclk);
        cfg_index <= blpc_pkg::REG_MEDIUM;
        cfg_wdata <= mid;
        @(posedge aclk);
        cfg_index <= blpc_pkg::REG_FAST;
        cfg_wdata <= fast;
        @(posedge aclk);
        cfg_index <= blpc_pkg::REG_BURST;
        cfg_wdata <= burst;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        slow_ticks   = slow;
        medium_ticks = mid;
        fast_ticks   = fast;
        burst_ticks  = burst;
        period_settings++;
    endtask

    // Mostly short periods so bursts finish; now and then zero, one or long ones.
    function automatic logic [blpc_pkg::PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 19))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            3:       return blpc_pkg::PERIOD_W'($urandom_range(128, 254));
            default: return blpc_pkg::PERIOD_W'($urandom_range(2, 12));
        endcase
    endfunction

    // Steady on on every LED, off on red, an unused select and tick fields that must be ignored.
    task automatic test_steady_levels();
        send_request(blpc_pkg::MODE_CMD, SEL_GREEN, blpc_pkg::PAT_ON);
        send_request(blpc_pkg::MODE_CMD, SEL_RED, blpc_pkg::PAT_ON);
        send_request(blpc_pkg::MODE_CMD, SEL_BLUE, blpc_pkg::PAT_ON);
        send_request(blpc_pkg::MODE_CMD, SEL_RED, blpc_pkg::PAT_OFF);
        send_request(blpc_pkg::MODE_CMD, SEL_NONE, blpc_pkg::PAT_ON);
        send_request(blpc_pkg::MODE_TICK, SEL_NONE, blpc_pkg::PAT_BURST5);
        wait_for_idle();
    endtask

    // Reset periods: fast blink on green and a single blink on blue that runs out.
    task automatic test_default_blink();
        send_request(blpc_pkg::MODE_CMD, SEL_GREEN, blpc_pkg::PAT_FAST);
        send_request(blpc_pkg::MODE_CMD, SEL_BLUE, blpc_pkg::PAT_BURST1);
        repeat (11) send_tick();
        wait_for_idle();
    endtask

    // Period extremes: zero leaves the LED inactive, one keeps it high on every tick, 255 is longest.
    task automatic test_period_extremes();
        write_periods(8'd0, 8'd1, 8'd255, 8'd2);
        send_request(blpc_pkg::MODE_CMD, SEL_GREEN, blpc_pkg::PAT_SLOW);
        send_request(blpc_pkg::MODE_CMD, SEL_RED, blpc_pkg::PAT_MEDIUM);
        send_request(blpc_pkg::MODE_CMD, SEL_BLUE, blpc_pkg::PAT_BURST3);
        repeat (3) send_tick();
        send_request(blpc_pkg::MODE_CMD, SEL_GREEN, blpc_pkg::PAT_FAST);
        send_tick();
        wait_for_idle();
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_stall_pressure();
        write_periods(blpc_pkg::FAST_RESET, blpc_pkg::FAST_RESET, 8'd3, 8'd2);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        send_request(blpc_pkg::MODE_CMD, SEL_GREEN, blpc_pkg::PAT_BURST5);
        send_request(blpc_pkg::MODE_CMD, SEL_RED, blpc_pkg::PAT_FAST);
        repeat (28) send_tick();
        wait_for_idle();
    endtask

    // Random traffic: command groups followed by tick runs, with some noise requests.
    task automatic test_random_traffic(input int item_count, input int send_pct,
                                       input int recv_pct);
        int sent;
        int run_len;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        write_periods(pick_period(), pick_period(), pick_period(), pick_period());
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(1'($urandom_range(0, 1)),
                             blpc_pkg::SEL_W'($urandom_range(0, 3)),
                             blpc_pkg::PAT_W'($urandom_range(0, 7)));
                sent++;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(blpc_pkg::MODE_CMD,
                                 blpc_pkg::SEL_W'($urandom_range(SEL_GREEN, SEL_BLUE)),
                                 blpc_pkg::PAT_W'($urandom_range(0, 7)));
                    sent++;
                end
                run_len = $urandom_range(1, 40);
                repeat (run_len) send_tick();
                sent += run_len;
            end
        end
        wait_for_idle();
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = blpc_pkg::REG_SLOW;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_mode       = blpc_pkg::MODE_TICK;
        s_led_select = SEL_GREEN;
        s_pattern    = blpc_pkg::PAT_OFF;
        slow_ticks   = blpc_pkg::SLOW_RESET;
        medium_ticks = blpc_pkg::MEDIUM_RESET;
        fast_ticks   = blpc_pkg::FAST_RESET;
        burst_ticks  = blpc_pkg::BURST_RESET;
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_period[i]      = '0;
            led_count[i]       = '0;
            led_blinks_left[i] = '0;
            led_burst[i]       = 1'b0;
            led_on[i]          = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_steady_levels();
        test_default_blink();
        test_period_extremes();
        test_stall_pressure();
        test_random_traffic(310, 26, 53);
        test_random_traffic(310, 26, 53);
        test_random_traffic(310, 53, 26);
        test_random_traffic(310, 53, 26);
        test_random_traffic(310, 0, 0);
        test_random_traffic(310, 0, 0);
        repeat (4) @(posedge aclk);

        $display("Run covered %0d requests (%0d ticks, %0d commands) under %0d period settings.",
                 tick_requests + command_requests, tick_requests, command_requests,
                 period_settings);
        $display("Checked %0d results; %0d bursts ran out; long receiver stall included.",
                 results_checked, bursts_finished);
        if (mismatch_count == 0 && pending_led_reports.size() == 0) begin
            $display("[led_blink_pattern_controller_unit] OK");
        end else begin
            $display("[led_blink_pattern_controller_unit] ERROR");
        end
        $finish;
    end

endmodule
